/* rtl/sbc_pkg.sv */
// shared widths, codes and types for the swept box collision pipeline
package sbc_pkg;

  // input field widths
  localparam int POS_W  = 24;
  localparam int SIZE_W = 23;
  localparam int VEL_W  = 24;

  // input beat layout
  localparam int IN_FIELDS_W = 2 * (4 * POS_W + 2 * SIZE_W);
  localparam int IN_W        = ((IN_FIELDS_W + 7) / 8) * 8;

  // internal widths
  localparam int REL_W  = VEL_W + 1;   // relative velocity
  localparam int END_W  = POS_W + 2;   // pos + size
  localparam int NUM_W  = END_W + 1;   // time numerator
  localparam int DEN_W  = REL_W;       // |relative velocity|
  localparam int PROD_W = NUM_W + DEN_W + 1;
  localparam int SW_W   = END_W + 1;   // swept box edges
  localparam int R_W    = DEN_W + 1;   // divider remainder

  // default time fraction bits
  localparam int TIME_BITS_DEF = 16;

  // contact normal codes
  localparam logic [1:0] NRM_ZERO = 2'b00;
  localparam logic [1:0] NRM_POS  = 2'b01;
  localparam logic [1:0] NRM_NEG  = 2'b11;

  // flags that ride along with the divider
  typedef struct packed {
    logic       hit;
    logic       zero_t;
    logic [1:0] nx;
    logic [1:0] ny;
  } sbc_side_t;

  // per-axis entry and exit time, kept as rationals over a common denominator
  typedef struct packed {
    logic                    inf;
    logic signed [NUM_W-1:0] en;
    logic signed [NUM_W-1:0] xn;
    logic [DEN_W-1:0]        den;
  } sbc_axis_t;

endpackage

/* rtl/swept_box_collision.sv */
// top level: swept box collision test, one box pair per beat
//
// Each input beat carries two boxes (position, size, per-frame motion); each
// output beat gives hit, entry time in Q1.TIME_BITS and the contact normal.
// The block takes one beat every cycle unless the pipeline is held, passing it
// through five stages for relative motion, the broad-phase test and the
// cross-multiplied time compares, one divider stage per quotient bit for the
// entry time, and the output register. While the output register is full,
// out_tready low holds the whole pipeline and in_tready follows out_tready.
module swept_box_collision #(
  parameter  int TIME_BITS = sbc_pkg::TIME_BITS_DEF,
  localparam int OUT_W     = ((TIME_BITS + 6 + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // a_pos_x, a_pos_y, a_width, a_height, a_vel_x, a_vel_y,
  // b_pos_x, b_pos_y, b_width, b_height, b_vel_x, b_vel_y, zero fill
  input  logic [sbc_pkg::IN_W-1:0] in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // hit, entry_time, normal_x, normal_y, zero fill
  output logic [OUT_W-1:0]       out_tdata
);
  import sbc_pkg::*;

  logic en;

  // input fields
  logic signed [POS_W-1:0] ax, ay, bx, by, avx, avy, bvx, bvy;
  logic [SIZE_W-1:0]       aw, ah, bw, bh;

  // stage a
  logic                    a_vld_r;
  logic signed [REL_W-1:0] a_vx_r, a_vy_r;
  logic signed [POS_W-1:0] a_ax_r, a_ay_r, a_bx_r, a_by_r;
  logic signed [END_W-1:0] a_aex_r, a_aey_r, a_bex_r, a_bey_r;

  // stage b
  logic      b_vld_r, b_miss_r, b_vxp_r, b_vyp_r;
  sbc_axis_t b_xa_r, b_ya_r;
  logic      b_miss_nxt;
  sbc_axis_t b_xa_nxt, b_ya_nxt;
  logic signed [SW_W-1:0] rx, lx, ry, ly;
  logic vxp, vxn, vyp, vyn;

  // stage c
  logic      c_vld_r, c_miss_r, c_vxp_r, c_vyp_r;
  sbc_axis_t c_xa_r, c_ya_r;
  logic signed [PROD_W-1:0] c_pe1_r, c_pe2_r, c_px1_r, c_px2_r;

  // stage d
  logic d_vld_r, d_miss_r, d_ent_inf_r, d_ext_inf_r;
  logic signed [NUM_W-1:0] d_ent_num_r, d_ext_num_r;
  logic [DEN_W-1:0]        d_ent_den_r, d_ext_den_r;
  logic [1:0]              d_nx_r, d_ny_r;
  logic e_gt, e_ge, x_le, xneg, yneg, xover, yover;
  logic [1:0] nx_nxt, ny_nxt;

  // stage e
  logic e_vld_r, e_miss_r, e_ent_inf_r, e_ext_inf_r;
  logic signed [NUM_W-1:0] e_ent_num_r;
  logic [DEN_W-1:0]        e_ent_den_r;
  logic [1:0]              e_nx_r, e_ny_r;
  logic signed [PROD_W-1:0] e_p1_r, e_p2_r;

  // divider feed and result
  sbc_side_t f_side;
  logic      f_gt;
  logic      dv_vld;
  logic [TIME_BITS:0] dv_q;
  sbc_side_t dv_side;
  logic [TIME_BITS:0] ent_t;

  // output register
  logic             out_tvalid_r;
  logic [OUT_W-1:0] out_tdata_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // unpack input beat
  assign ax  = in_tdata[23:0];
  assign ay  = in_tdata[47:24];
  assign aw  = in_tdata[70:48];
  assign ah  = in_tdata[93:71];
  assign avx = in_tdata[117:94];
  assign avy = in_tdata[141:118];
  assign bx  = in_tdata[165:142];
  assign by  = in_tdata[189:166];
  assign bw  = in_tdata[212:190];
  assign bh  = in_tdata[235:213];
  assign bvx = in_tdata[259:236];
  assign bvy = in_tdata[283:260];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  // stage a: relative motion and far edges
  always_ff @(posedge clk) begin
    if (en) begin
      a_vx_r  <= REL_W'(avx) - REL_W'(bvx);
      a_vy_r  <= REL_W'(avy) - REL_W'(bvy);
      a_ax_r  <= ax;
      a_ay_r  <= ay;
      a_bx_r  <= bx;
      a_by_r  <= by;
      a_aex_r <= END_W'(ax) + $signed({3'b0, aw});
      a_aey_r <= END_W'(ay) + $signed({3'b0, ah});
      a_bex_r <= END_W'(bx) + $signed({3'b0, bw});
      a_bey_r <= END_W'(by) + $signed({3'b0, bh});
    end
  end

  // stage b: broad phase and per-axis time numerators
  assign vxn = a_vx_r[REL_W-1];
  assign vyn = a_vy_r[REL_W-1];
  assign vxp = !vxn && (a_vx_r != '0);
  assign vyp = !vyn && (a_vy_r != '0);

  always_comb begin
    rx = SW_W'(a_aex_r) + (vxp ? SW_W'(a_vx_r) : '0);
    lx = SW_W'(a_ax_r)  + (vxn ? SW_W'(a_vx_r) : '0);
    ry = SW_W'(a_aey_r) + (vyp ? SW_W'(a_vy_r) : '0);
    ly = SW_W'(a_ay_r)  + (vyn ? SW_W'(a_vy_r) : '0);
    b_miss_nxt = (rx < SW_W'(a_bx_r)) || (lx > SW_W'(a_bex_r)) ||
                 (ry < SW_W'(a_by_r)) || (ly > SW_W'(a_bey_r));

    b_xa_nxt.inf = !vxp && !vxn;
    b_xa_nxt.en  = vxp ? NUM_W'(a_bx_r) - NUM_W'(a_aex_r) : NUM_W'(a_ax_r) - NUM_W'(a_bex_r);
    b_xa_nxt.xn  = vxp ? NUM_W'(a_bex_r) - NUM_W'(a_ax_r) : NUM_W'(a_aex_r) - NUM_W'(a_bx_r);
    b_xa_nxt.den = vxn ? DEN_W'(-a_vx_r) : DEN_W'(a_vx_r);

    b_ya_nxt.inf = !vyp && !vyn;
    b_ya_nxt.en  = vyp ? NUM_W'(a_by_r) - NUM_W'(a_aey_r) : NUM_W'(a_ay_r) - NUM_W'(a_bey_r);
    b_ya_nxt.xn  = vyp ? NUM_W'(a_bey_r) - NUM_W'(a_ay_r) : NUM_W'(a_aey_r) - NUM_W'(a_by_r);
    b_ya_nxt.den = vyn ? DEN_W'(-a_vy_r) : DEN_W'(a_vy_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_miss_r <= b_miss_nxt;
      b_xa_r   <= b_xa_nxt;
      b_ya_r   <= b_ya_nxt;
      b_vxp_r  <= vxp;
      b_vyp_r  <= vyp;
    end
  end

  // stage c: cross products for entry and exit compares
  always_ff @(posedge clk) begin
    if (en) begin
      c_pe1_r  <= b_xa_r.en * $signed({1'b0, b_ya_r.den});
      c_pe2_r  <= b_ya_r.en * $signed({1'b0, b_xa_r.den});
      c_px1_r  <= b_xa_r.xn * $signed({1'b0, b_ya_r.den});
      c_px2_r  <= b_ya_r.xn * $signed({1'b0, b_xa_r.den});
      c_xa_r   <= b_xa_r;
      c_ya_r   <= b_ya_r;
      c_miss_r <= b_miss_r;
      c_vxp_r  <= b_vxp_r;
      c_vyp_r  <= b_vyp_r;
    end
  end

  // stage d: latest entry, earliest exit, range checks, normal
  always_comb begin
    if (c_xa_r.inf && c_ya_r.inf) begin
      e_gt = 1'b0;
      e_ge = 1'b1;
      x_le = 1'b1;
    end else if (c_xa_r.inf) begin
      e_gt = 1'b0;
      e_ge = 1'b0;
      x_le = 1'b0;
    end else if (c_ya_r.inf) begin
      e_gt = 1'b1;
      e_ge = 1'b1;
      x_le = 1'b1;
    end else begin
      e_gt = c_pe1_r > c_pe2_r;
      e_ge = c_pe1_r >= c_pe2_r;
      x_le = c_px1_r <= c_px2_r;
    end
    xneg  = c_xa_r.inf || c_xa_r.en[NUM_W-1];
    yneg  = c_ya_r.inf || c_ya_r.en[NUM_W-1];
    xover = !c_xa_r.inf && (c_xa_r.en > $signed({2'b0, c_xa_r.den}));
    yover = !c_ya_r.inf && (c_ya_r.en > $signed({2'b0, c_ya_r.den}));
    if (e_gt) begin
      nx_nxt = c_vxp_r ? NRM_NEG : NRM_POS;
      ny_nxt = NRM_ZERO;
    end else begin
      nx_nxt = NRM_ZERO;
      ny_nxt = c_vyp_r ? NRM_POS : NRM_NEG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_miss_r    <= c_miss_r || (xneg && yneg) || xover || yover;
      d_ent_inf_r <= e_ge ? c_xa_r.inf : c_ya_r.inf;
      d_ent_num_r <= e_ge ? c_xa_r.en  : c_ya_r.en;
      d_ent_den_r <= e_ge ? c_xa_r.den : c_ya_r.den;
      d_ext_inf_r <= x_le ? c_xa_r.inf : c_ya_r.inf;
      d_ext_num_r <= x_le ? c_xa_r.xn  : c_ya_r.xn;
      d_ext_den_r <= x_le ? c_xa_r.den : c_ya_r.den;
      d_nx_r      <= nx_nxt;
      d_ny_r      <= ny_nxt;
    end
  end

  // stage e: entry against exit cross products
  always_ff @(posedge clk) begin
    if (en) begin
      e_p1_r      <= d_ent_num_r * $signed({1'b0, d_ext_den_r});
      e_p2_r      <= d_ext_num_r * $signed({1'b0, d_ent_den_r});
      e_miss_r    <= d_miss_r;
      e_ent_inf_r <= d_ent_inf_r;
      e_ext_inf_r <= d_ext_inf_r;
      e_ent_num_r <= d_ent_num_r;
      e_ent_den_r <= d_ent_den_r;
      e_nx_r      <= d_nx_r;
      e_ny_r      <= d_ny_r;
    end
  end

  // final hit decision, then hand entry time to the divider
  always_comb begin
    f_gt          = !e_ent_inf_r && !e_ext_inf_r && (e_p1_r > e_p2_r);
    f_side.hit    = !(e_miss_r || f_gt);
    f_side.zero_t = e_ent_inf_r || e_ent_num_r[NUM_W-1];
    f_side.nx     = f_side.hit ? e_nx_r : NRM_ZERO;
    f_side.ny     = f_side.hit ? e_ny_r : NRM_ZERO;
  end

  sbc_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (e_vld_r),
    .in_num   (e_ent_num_r[R_W-1:0]),
    .in_den   (e_ent_den_r),
    .in_side  (f_side),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  // entry time select
  always_comb begin
    if (!dv_side.hit) begin
      ent_t = {1'b1, {TIME_BITS{1'b0}}};
    end else if (dv_side.zero_t) begin
      ent_t = '0;
    end else begin
      ent_t = dv_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= OUT_W'({dv_side.ny, dv_side.nx, ent_t, dv_side.hit});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* rtl/sbc_div.sv */
// pipelined restoring divider, one quotient bit per stage
module sbc_div #(
  parameter int TIME_BITS = sbc_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [sbc_pkg::R_W-1:0]  in_num,
  input  logic [sbc_pkg::DEN_W-1:0] in_den,
  input  sbc_pkg::sbc_side_t       in_side,
  output logic                     out_vld,
  output logic [TIME_BITS:0]       out_q,
  output sbc_pkg::sbc_side_t       out_side
);
  import sbc_pkg::*;

  localparam int NSTG = TIME_BITS + 1;

  logic [NSTG-1:0]  vld_r;
  logic [R_W-1:0]   rem_r  [NSTG];
  logic [DEN_W-1:0] den_r  [NSTG];
  logic [TIME_BITS:0] q_r  [NSTG];
  sbc_side_t        side_r [NSTG];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_stg
      logic [R_W-1:0]     rem_in;
      logic [DEN_W-1:0]   den_in;
      logic [TIME_BITS:0] q_in;
      sbc_side_t          side_in;
      logic               ge;

      // first stage takes the dividend unshifted, later stages shift in a zero
      if (k == 0) begin : g_first
        assign rem_in  = in_num;
        assign den_in  = in_den;
        assign q_in    = '0;
        assign side_in = in_side;
      end else begin : g_next
        assign rem_in  = {rem_r[k-1][R_W-2:0], 1'b0};
        assign den_in  = den_r[k-1];
        assign q_in    = q_r[k-1];
        assign side_in = side_r[k-1];
      end

      assign ge = rem_in >= {1'b0, den_in};

      // trial subtract
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? rem_in - {1'b0, den_in} : rem_in;
          den_r[k]  <= den_in;
          q_r[k]    <= {q_in[TIME_BITS-1:0], ge};
          side_r[k] <= side_in;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[NSTG-1];
  assign out_q    = q_r[NSTG-1];
  assign out_side = side_r[NSTG-1];

endmodule
